@@ design/pip_pkg.sv @@
// Shared types, constants and controller/datapath interface structs
// for the ray-casting point-in-polygon block. No dependencies.
package pip_pkg;

   localparam int COORD_BITS   = 16;
   localparam int MAX_VERTICES = 16;
   localparam int IDX_BITS     = 4;   // vertex_index field width
   localparam int CNT_BITS     = 5;   // vertex_count register width
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * DIFF_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [IDX_BITS-1:0]   idx_type;
   typedef logic        [CNT_BITS-1:0]   cnt_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TEST = 1'b1
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PRIME = 5'b00010,
      ST_WALK  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic    wr_en;    // write request vertex into table
      logic    start;    // latch test point, clear parity flag
      logic    rd_en;    // read one table entry
      logic    rd_edge;  // entry read closes an edge (not the priming read)
      idx_type rd_addr;
      logic    push;     // move parity flag into response register
   } cmd_type;

   typedef struct packed {
      logic busy;        // edge pipeline still holds work
      logic rsp_valid;   // response register occupied
   } status_type;

endpackage

@@ design/pip_datapath.sv @@
// Datapath: vertex table, edge pipeline (diff, multiply, compare) and
// the response register. Depends on pip_pkg.
module pip_datapath (
   input  logic                clock,
   input  logic                reset,
   input  pip_pkg::cmd_type    cmd,
   output pip_pkg::status_type status,
   input  pip_pkg::idx_type    req_vertex_index,
   input  pip_pkg::coord_type  req_point_x,
   input  pip_pkg::coord_type  req_point_y,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_inside_res
);
   import pip_pkg::*;

   // vertex table, x and y packed
   logic [2*COORD_BITS-1:0] vtx_mem [MAX_VERTICES];
   logic [2*COORD_BITS-1:0] rd_data_ff;
   logic [2*COORD_BITS-1:0] prev_ff;

   coord_type pt_x_ff, pt_y_ff;
   logic      rd_vld_ff, rd_edge_ff;

   // stage 1
   logic                        s1_vld_ff, s1_strad_ff, s1_dypos_ff;
   logic signed [DIFF_BITS-1:0] s1_dy_ff, s1_px_ff, s1_ex_ff, s1_py_ff;
   // stage 2
   logic                        s2_vld_ff, s2_strad_ff, s2_dypos_ff;
   logic signed [PROD_BITS-1:0] s2_p1_ff, s2_p2_ff;

   logic flag_ff;
   logic rsp_valid_ff, rsp_res_ff;

   coord_type xi, yi, xj, yj;
   logic      strad_in, left;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         vtx_mem[req_vertex_index] <= {req_point_x, req_point_y};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= vtx_mem[cmd.rd_addr];
      end
   end

   assign xi = coord_type'(rd_data_ff[2*COORD_BITS-1:COORD_BITS]);
   assign yi = coord_type'(rd_data_ff[COORD_BITS-1:0]);
   assign xj = coord_type'(prev_ff[2*COORD_BITS-1:COORD_BITS]);
   assign yj = coord_type'(prev_ff[COORD_BITS-1:0]);

   assign strad_in = (yi > pt_y_ff) != (yj > pt_y_ff);

   // exact compare of px*dy against ex*py, sense flipped for falling edges
   assign left = s2_dypos_ff ? (s2_p1_ff < s2_p2_ff) : (s2_p2_ff < s2_p1_ff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pt_x_ff <= req_point_x;
         pt_y_ff <= req_point_y;
      end
      if (rd_vld_ff) begin
         prev_ff <= rd_data_ff;
      end
      s1_strad_ff <= strad_in;
      s1_dy_ff    <= DIFF_BITS'(yj) - DIFF_BITS'(yi);
      s1_dypos_ff <= yj > yi;
      s1_px_ff    <= DIFF_BITS'(pt_x_ff) - DIFF_BITS'(xi);
      s1_ex_ff    <= DIFF_BITS'(xj) - DIFF_BITS'(xi);
      s1_py_ff    <= DIFF_BITS'(pt_y_ff) - DIFF_BITS'(yi);
      s2_strad_ff <= s1_strad_ff;
      s2_dypos_ff <= s1_dypos_ff;
      s2_p1_ff    <= s1_px_ff * s1_dy_ff;
      s2_p2_ff    <= s1_ex_ff * s1_py_ff;
      if (cmd.push) begin
         rsp_res_ff <= flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         rd_edge_ff   <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= cmd.rd_en;
         rd_edge_ff <= cmd.rd_en & cmd.rd_edge;
         s1_vld_ff  <= rd_vld_ff & rd_edge_ff;
         s2_vld_ff  <= s1_vld_ff;
         if (cmd.start) begin
            flag_ff <= 1'b0;
         end else if (s2_vld_ff && s2_strad_ff && left) begin
            flag_ff <= ~flag_ff;
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.busy      = rd_vld_ff | s1_vld_ff | s2_vld_ff;
   assign status.rsp_valid = rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_inside_res   = rsp_res_ff;

endmodule

@@ design/pip_controller.sv @@
// Controller: request decode, vertex_count register and the edge walk
// sequencer. Depends on pip_pkg.
module pip_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  pip_pkg::cnt_type    csr_vertex_count,
   input  logic                rsp_ready,
   input  pip_pkg::status_type status,
   output pip_pkg::cmd_type    cmd
);
   import pip_pkg::*;

   state_type state_ff, state_in;
   cnt_type   vcount_ff;
   cnt_type   n_ff, n_in;
   cnt_type   idx_ff, idx_in;
   cnt_type   n_sat;
   cnt_type   n_last;

   // counts beyond the table size saturate
   assign n_sat  = (vcount_ff > CNT_BITS'(MAX_VERTICES)) ? CNT_BITS'(MAX_VERTICES)
                                                         : vcount_ff;
   assign n_last = n_ff - CNT_BITS'(1);

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      idx_in      = idx_ff;
      cmd         = '0;
      cmd.rd_addr = idx_ff[IDX_BITS-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_LOAD) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  n_in      = n_sat;
                  state_in  = (n_sat == '0) ? ST_DONE : ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            // previous vertex of edge 0 is the last vertex
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = n_last[IDX_BITS-1:0];
            idx_in      = '0;
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_edge = 1'b1;
            idx_in      = idx_ff + CNT_BITS'(1);
            if (idx_ff == n_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.rsp_valid || rsp_ready) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         vcount_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            vcount_ff <= csr_vertex_count;
         end
      end
   end

endmodule

@@ design/point_in_polygon_ray_cast.sv @@
// A load request is written in the cycle it is accepted and gives no response.
// A test with n > 0 vertices runs one priming read, one edge read per vertex, a drain of
// the edge pipeline and a hand-off into the response register; with n = 0, only the hand-off.
// Loads are taken one per cycle while no test is in progress; a test holds the request port
// until its hand-off, longer while an earlier response still waits. One test at a time.
// Reset (synchronous, active high) clears vertex_count and control; table not cleared.
module point_in_polygon_ray_cast (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  pip_pkg::idx_type   req_vertex_index,
   input  pip_pkg::coord_type req_point_x,
   input  pip_pkg::coord_type req_point_y,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_inside_res,
   // vertex_count register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  pip_pkg::cnt_type   csr_vertex_count
);
   import pip_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: walks edges (last,0), (0,1) ... and hands results out
   pip_controller u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_vertex_count (csr_vertex_count),
      .rsp_ready        (rsp_ready),
      .status           (status),
      .cmd              (cmd)
   );

   // table, edge pipeline and response register; the response register
   // lets a new request in while an earlier result waits to be taken
   pip_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_vertex_index (req_vertex_index),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_inside_res   (rsp_inside_res)
   );

endmodule

@@ design/pip_checker.sv @@
// Port-level checker for point_in_polygon_ray_cast, bound to the top level.
// Depends on pip_pkg.
module pip_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_op,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_inside_res
);
   import pip_pkg::*;

   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inside_res))
      else $error("response changed while stalled");

   // a test request occupies the sequencer: no request taken next cycle
   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_TEST) |=> !req_ready)
      else $error("request taken right after a test request");

   // a new response appears only as the sequencer finishes a test
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without a test in progress");

endmodule

bind point_in_polygon_ray_cast pip_checker u_pip_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_op         (req_op),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_inside_res (rsp_inside_res)
);

@@ tb/point_in_polygon_ray_cast_tb.sv @@
// Self-checking bench for point_in_polygon_ray_cast: random and directed vertex loads,
// point tests and vertex_count writes. Depends on pip_pkg and the block's RTL only.
module point_in_polygon_ray_cast_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pip_pkg::*;

   // One pending parity verdict, kept with its point for the mismatch line.
   typedef struct {
      coord_type x;
      coord_type y;
      bit        is_in;
   } verdict_type;

   // Shadow of the vertex table and vertex_count. It works out the even-odd
   // verdict for every accepted test and checks responses in order.
   class inside_scoreboard;
      coord_type   vx[MAX_VERTICES];
      coord_type   vy[MAX_VERTICES];
      cnt_type     vertex_count;
      verdict_type verdict_q[$];
      int          errors;
      int          loads_seen;
      int          tests_seen;
      int          inside_seen;
      int          count_writes;

      function new();
         vertex_count = '0;
         errors       = 0;
         loads_seen   = 0;
         tests_seen   = 0;
         inside_seen  = 0;
         count_writes = 0;
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction

      function void set_count(cnt_type c);
         vertex_count = c;
         count_writes++;
      endfunction

      // Even-odd ray cast with the crossing compare cross-multiplied and
      // flipped for a falling edge. Horizontal edges never straddle.
      function bit ray_parity(coord_type x, coord_type y);
         int     n;
         int     j;
         longint xi, yi, xj, yj, dy, px, ex, py;
         bit     flag;
         bit     left;
         n    = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
         flag = 1'b0;
         j    = n - 1;
         for (int i = 0; i < n; i++) begin
            xi = vx[i];
            yi = vy[i];
            xj = vx[j];
            yj = vy[j];
            if ((yi > longint'(y)) != (yj > longint'(y))) begin
               dy = yj - yi;
               px = longint'(x) - xi;
               ex = xj - xi;
               py = longint'(y) - yi;
               if (dy > 0)
                  left = (px * dy) < (ex * py);
               else
                  left = (ex * py) < (px * dy);
               if (left)
                  flag = ~flag;
            end
            j = i;
         end
         return flag;
      endfunction

      function void note_request(op_type op, idx_type idx, coord_type x, coord_type y);
         verdict_type v;
         if (op == OP_LOAD) begin
            vx[idx] = x;
            vy[idx] = y;
            loads_seen++;
         end else begin
            v.x     = x;
            v.y     = y;
            v.is_in = ray_parity(x, y);
            verdict_q.push_back(v);
            tests_seen++;
            if (v.is_in)
               inside_seen++;
         end
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_response(logic got);
         verdict_type v;
         if (verdict_q.size() == 0) begin
            report($sformatf("response inside_res=%b with no test outstanding", got));
            return;
         end
         v = verdict_q.pop_front();
         if (got !== v.is_in)
            report($sformatf("point (%0d,%0d) count %0d: inside_res=%b, want %b",
                             v.x, v.y, vertex_count, got, v.is_in));
      endtask
   endclass

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   logic      req_op;
   idx_type   req_vertex_index;
   coord_type req_point_x;
   coord_type req_point_y;
   logic      rsp_valid;
   logic      rsp_ready;
   logic      rsp_inside_res;
   logic      csr_valid;
   logic      csr_ready;
   cnt_type   csr_vertex_count;

   inside_scoreboard board;
   bit gaps_on;            // random idling on both channels
   bit hold_off_pending;   // asks the response side for one long stall

   point_in_polygon_ray_cast dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_vertex_index (req_vertex_index),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_inside_res   (rsp_inside_res),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_vertex_count (csr_vertex_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop; the slowest legal run is far shorter than this.
   initial begin
      #5_000_000;
      $display("timeout: %0d tests still outstanding", board.pending());
      $display("status: fail");
      $finish;
   end

   // Monitor: every handshake is sampled at the edge where it completes,
   // using pre-edge values, so driver/monitor ordering does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            board.set_count(csr_vertex_count);
         if (req_valid && req_ready)
            board.note_request(op_type'(req_op), req_vertex_index, req_point_x, req_point_y);
         if (rsp_valid && rsp_ready)
            board.check_response(rsp_inside_res);
      end
   end

   // Response side: random back-pressure, plus one long hold-off on request.
   // The hold-off is counted here so the sender keeps offering meanwhile and
   // the block backs up into its request port.
   initial begin
      int stall_left;
      bit hold_taken;
      stall_left = 0;
      hold_taken = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !gaps_on || ($urandom_range(99) >= 37);
         end
      end
   end

   // Random coordinate in [-span, span-1]; span of 32768 is the full signed 16-bit integer (Q16.0) range.
   function automatic coord_type rand_coord(int span);
      return coord_type'(int'($urandom_range(2 * span - 1)) - span);
   endfunction

   // Offers one request and returns at the edge where it is taken.
   // valid stays up between back-to-back requests; it only drops for a gap.
   task automatic send_request(op_type op, idx_type idx, coord_type x, coord_type y);
      if (gaps_on) begin
         while ($urandom_range(99) < 37) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_vertex_index <= idx;
      req_point_x      <= x;
      req_point_y      <= y;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Quiesce: stop offering, let every outstanding test answer, then allow
   // for a full walk before touching the register.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_count(cnt_type c);
      csr_valid        <= 1'b1;
      csr_vertex_count <= c;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int        span;
      int        n_eff;
      int        k;
      int        m;
      cnt_type   cnt;
      coord_type px, py;

      board            = new();
      gaps_on          = 1'b1;
      hold_off_pending = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = 1'b0;
      req_vertex_index = '0;
      req_point_x      = '0;
      req_point_y      = '0;
      csr_valid        = 1'b0;
      csr_vertex_count = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // vertex_count is zero out of reset: empty polygon reads outside.
      send_request(OP_TEST, 4'd0, 16'sd0, 16'sd0);
      // Full-range square; top and bottom edges are horizontal.
      send_request(OP_LOAD, 4'd0, -16'sd32768, -16'sd32768);
      send_request(OP_LOAD, 4'd1,  16'sd32767, -16'sd32768);
      send_request(OP_LOAD, 4'd2,  16'sd32767,  16'sd32767);
      send_request(OP_LOAD, 4'd3, -16'sd32768,  16'sd32767);
      settle();
      write_count(cnt_type'(4));
      send_request(OP_TEST, 4'd0, 16'sd0, 16'sd0);                // deep inside
      send_request(OP_TEST, 4'd0, -16'sd32768, 16'sd0);           // on left edge
      send_request(OP_TEST, 4'd0, 16'sd32767, 16'sd0);            // on right edge
      send_request(OP_TEST, 4'd0, 16'sd0, -16'sd32768);           // on bottom edge
      send_request(OP_TEST, 4'd0, 16'sd32767, 16'sd32767);        // a corner
      send_request(OP_TEST, 4'd0, -16'sd32768, -16'sd32768);      // other corner
      // Fill the rest with copies of the last corner: degenerate flat edges.
      for (int s = 4; s < MAX_VERTICES; s++)
         send_request(OP_LOAD, idx_type'(s), -16'sd32768, 16'sd32767);
      settle();
      // Count above the table depth saturates to all 16 slots.
      write_count(cnt_type'(31));
      send_request(OP_TEST, 4'd0, 16'sd1, -16'sd1);
      send_request(OP_TEST, 4'd0, -16'sd32767, 16'sd32766);
      settle();

      // --- random phases: fresh polygon and count each time ---
      for (int phase = 0; phase < 12; phase++) begin
         gaps_on = !(phase == 5 || phase == 6);   // two phases run flat out
         case (phase)
            0: cnt = cnt_type'(MAX_VERTICES);
            1: cnt = cnt_type'(31);
            2: cnt = cnt_type'(3);
            default: begin
               case ($urandom_range(9))
                  0:       cnt = '0;
                  1:       cnt = cnt_type'($urandom_range(17, 31));
                  2:       cnt = cnt_type'($urandom_range(1, 2));
                  default: cnt = cnt_type'($urandom_range(3, 16));
               endcase
            end
         endcase
         write_count(cnt);
         n_eff = (cnt > MAX_VERTICES) ? MAX_VERTICES : int'(cnt);
         // Mostly compact polygons so tests land near edges; some full range.
         span = ($urandom_range(3) == 0) ? 32768 : (1 << $urandom_range(3, 14));
         for (int s = 0; s < MAX_VERTICES; s++)
            send_request(OP_LOAD, idx_type'(s), rand_coord(span), rand_coord(span));
         if (phase == 3)
            hold_off_pending = 1'b1;
         repeat (90) begin
            if ($urandom_range(99) < 15) begin
               // reshape the polygon on the fly
               send_request(OP_LOAD, idx_type'($urandom_range(MAX_VERTICES - 1)),
                            rand_coord(span), rand_coord(span));
            end else begin
               k = (n_eff > 0) ? $urandom_range(n_eff - 1) : 0;
               m = (k == 0) ? n_eff - 1 : k - 1;
               if (n_eff == 0) begin
                  px = rand_coord(32768);
                  py = rand_coord(32768);
               end else begin
                  case ($urandom_range(4))
                     0: begin
                        px = rand_coord(span);
                        py = rand_coord(span);
                     end
                     1: begin
                        px = rand_coord(32768);
                        py = rand_coord(32768);
                     end
                     2: begin   // exactly on a vertex
                        px = board.vx[k];
                        py = board.vy[k];
                     end
                     3: begin   // edge midpoint: on or next to the crossing
                        px = coord_type'((longint'(board.vx[k]) + board.vx[m]) >>> 1);
                        py = coord_type'((longint'(board.vy[k]) + board.vy[m]) >>> 1);
                     end
                     default: begin   // ray level with a vertex
                        px = rand_coord(span);
                        py = board.vy[k];
                     end
                  endcase
               end
               send_request(OP_TEST, idx_type'($urandom_range(MAX_VERTICES - 1)), px, py);
            end
         end
         settle();
      end

      $display("run covered %0d vertex loads and %0d point tests (%0d inside)",
               board.loads_seen, board.tests_seen, board.inside_seen);
      $display("over %0d vertex_count settings, including 0, 3, 16 and 31; %0d mismatches",
               board.count_writes, board.errors);
      if (board.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ point_in_polygon_ray_cast.f @@
design/pip_pkg.sv
design/pip_datapath.sv
design/pip_controller.sv
design/point_in_polygon_ray_cast.sv
design/pip_checker.sv
tb/point_in_polygon_ray_cast_tb.sv
